@@ design/oriented_box_corner_contact_unit_assert.svh @@
// assertion macros shared by the checker of the contact unit
// no other dependencies
`ifndef ORIENTED_BOX_CORNER_CONTACT_UNIT_ASSERT_SVH
`define ORIENTED_BOX_CORNER_CONTACT_UNIT_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define OBCC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("obcc check failed");

// next-cycle implication, disabled while reset is low
`define OBCC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("obcc check failed");

`endif

@@ design/obcc_pkg.sv @@
// types and constants of the oriented box corner contact unit
// no dependencies
`default_nettype none
package obcc_pkg;

    localparam int AW  = 40;        // multiplier operand a and corner coordinates
    localparam int BW  = 16;        // axis width, Q1.14
    localparam int PW  = AW + BW;   // product width
    localparam int ACW = PW + 2;    // accumulator width
    localparam int RW  = ACW - 14;  // rounded accumulator width
    localparam int SW  = 40;        // contact sum width
    localparam int PNW = 31;        // penetration width

    localparam int CORNER_STEPS = 14;
    localparam int FINAL_STEPS  = 7;
    localparam int PEN_STEPS    = 4;
    localparam int DIV_STEPS    = AW;

    localparam logic [1:0] ACT_LOAD  = 2'd0;
    localparam logic [1:0] ACT_TEST  = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;

    typedef enum logic [2:0] {A_X, A_Y, A_RX, A_RY, A_LX, A_LY} t_asel;
    typedef enum logic [1:0] {B_C, B_S, B_RC, B_RS} t_bsel;
    typedef enum logic [1:0] {ACC_NONE, ACC_LOAD, ACC_ADD, ACC_SUB} t_accop;
    typedef enum logic [2:0] {WB_NONE, WB_RX, WB_RY, WB_QX, WB_QY, WB_SX, WB_SY} t_wb;

    typedef struct packed {
        logic       capture;
        logic [1:0] corner;
        t_asel      asel;
        t_bsel      bsel;
        t_accop     accop;
        t_wb        wb;
        logic       bound_upd;
        logic       bound_first;
        logic       div_start;
        logic       div_step;
        logic       div_fin;
        logic       cnt_inc;
        logic       pen_try;
        logic [1:0] pen_idx;
    } t_cmd;

    typedef struct packed {
        logic test_ok;
    } t_stat;

endpackage
`default_nettype wire

@@ design/obcc_ctrl.sv @@
// sequencer of the contact unit: handshakes and datapath commands
// depends on obcc_pkg
`default_nettype none
module obcc_ctrl
    import obcc_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    input  wire logic [1:0] i_action,
    output logic            o_stall,
    output logic            o_valid,
    input  wire logic       i_stall,
    input  wire t_stat      i_stat,
    output t_cmd            o_cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_CORNER = 3'd1;
    localparam logic [2:0] ST_CHECK  = 3'd2;
    localparam logic [2:0] ST_DIV    = 3'd3;
    localparam logic [2:0] ST_DFIN   = 3'd4;
    localparam logic [2:0] ST_FINAL  = 3'd5;
    localparam logic [2:0] ST_PEN    = 3'd6;
    localparam logic [2:0] ST_OUT    = 3'd7;

    logic [2:0] r_state, n_state;
    logic [5:0] r_cnt, n_cnt;
    logic [1:0] r_corner, n_corner;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_cnt    <= '0;
            r_corner <= '0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_corner <= n_corner;
        end
    end

    assign o_stall = (r_state != ST_IDLE);
    assign o_valid = (r_state == ST_OUT);

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_corner = r_corner;
        o_cmd    = '0;
        o_cmd.corner = r_corner;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    n_cnt    = '0;
                    n_corner = '0;
                    n_state  = (i_action == ACT_TEST) ? ST_CORNER : ST_OUT;
                end
            end
            ST_CORNER: begin
                // one corner: offset, reference frame, bounds
                unique case (r_cnt[3:0])
                    4'd0:  begin o_cmd.asel = A_X; o_cmd.bsel = B_C; end
                    4'd1:  begin
                        o_cmd.asel = A_Y; o_cmd.bsel = B_S; o_cmd.accop = ACC_LOAD;
                    end
                    4'd2:  o_cmd.accop = ACC_SUB;
                    4'd3:  begin
                        o_cmd.wb = WB_RX; o_cmd.asel = A_X; o_cmd.bsel = B_S;
                    end
                    4'd4:  begin
                        o_cmd.asel = A_Y; o_cmd.bsel = B_C; o_cmd.accop = ACC_LOAD;
                    end
                    4'd5:  o_cmd.accop = ACC_ADD;
                    4'd6:  begin
                        o_cmd.wb = WB_RY; o_cmd.asel = A_RX; o_cmd.bsel = B_RC;
                    end
                    4'd7:  begin
                        o_cmd.asel = A_RY; o_cmd.bsel = B_RS; o_cmd.accop = ACC_LOAD;
                    end
                    4'd8:  o_cmd.accop = ACC_ADD;
                    4'd9:  begin
                        o_cmd.wb = WB_QX; o_cmd.asel = A_RY; o_cmd.bsel = B_RC;
                    end
                    4'd10: begin
                        o_cmd.asel = A_RX; o_cmd.bsel = B_RS; o_cmd.accop = ACC_LOAD;
                    end
                    4'd11: o_cmd.accop = ACC_SUB;
                    4'd12: o_cmd.wb = WB_QY;
                    default: begin
                        o_cmd.bound_upd   = 1'b1;
                        o_cmd.bound_first = (r_corner == 2'd0);
                    end
                endcase
                if (r_cnt == 6'(CORNER_STEPS - 1)) begin
                    n_cnt = '0;
                    if (r_corner == 2'd3) begin
                        n_state = ST_CHECK;
                    end else begin
                        n_corner = r_corner + 2'd1;
                    end
                end else begin
                    n_cnt = r_cnt + 6'd1;
                end
            end
            ST_CHECK: begin
                if (i_stat.test_ok) begin
                    o_cmd.div_start = 1'b1;
                    n_cnt   = '0;
                    n_state = ST_DIV;
                end else begin
                    n_state = ST_OUT;
                end
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_cnt == 6'(DIV_STEPS - 1)) begin
                    n_state = ST_DFIN;
                end else begin
                    n_cnt = r_cnt + 6'd1;
                end
            end
            ST_DFIN: begin
                o_cmd.div_fin = 1'b1;
                n_cnt   = '0;
                n_state = ST_FINAL;
            end
            ST_FINAL: begin
                // mean inside corner back to world frame
                unique case (r_cnt[2:0])
                    3'd0: begin o_cmd.asel = A_LX; o_cmd.bsel = B_RC; end
                    3'd1: begin
                        o_cmd.asel = A_LY; o_cmd.bsel = B_RS; o_cmd.accop = ACC_LOAD;
                    end
                    3'd2: o_cmd.accop = ACC_SUB;
                    3'd3: begin
                        o_cmd.wb = WB_SX; o_cmd.asel = A_LX; o_cmd.bsel = B_RS;
                        o_cmd.cnt_inc = 1'b1;
                    end
                    3'd4: begin
                        o_cmd.asel = A_LY; o_cmd.bsel = B_RC; o_cmd.accop = ACC_LOAD;
                    end
                    3'd5: o_cmd.accop = ACC_ADD;
                    default: o_cmd.wb = WB_SY;
                endcase
                if (r_cnt == 6'(FINAL_STEPS - 1)) begin
                    n_cnt   = '0;
                    n_state = ST_PEN;
                end else begin
                    n_cnt = r_cnt + 6'd1;
                end
            end
            ST_PEN: begin
                o_cmd.pen_try = 1'b1;
                o_cmd.pen_idx = r_cnt[1:0];
                if (r_cnt == 6'(PEN_STEPS - 1)) begin
                    n_state = ST_OUT;
                end else begin
                    n_cnt = r_cnt + 6'd1;
                end
            end
            default: begin
                if (!i_stall) begin
                    n_state = ST_IDLE;
                end
            end
        endcase
    end

endmodule
`default_nettype wire

@@ design/obcc_datapath.sv @@
// datapath of the contact unit: state, shared multiplier, divider, penetration
// depends on obcc_pkg
`default_nettype none
module obcc_datapath
    import obcc_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_cmd               i_cmd,
    output t_stat                   o_stat,
    input  wire logic [1:0]         i_action,
    input  wire logic signed [31:0] i_pos_x,
    input  wire logic signed [31:0] i_pos_y,
    input  wire logic signed [15:0] i_axis_cos,
    input  wire logic signed [15:0] i_axis_sin,
    input  wire logic [14:0]        i_width,
    input  wire logic [14:0]        i_height,
    output logic                    o_hit,
    output logic signed [SW-1:0]    o_contact_sum_x,
    output logic signed [SW-1:0]    o_contact_sum_y,
    output logic [3:0]              o_contact_count,
    output logic [PNW-1:0]          o_penetration,
    output logic signed [15:0]      o_normal_x,
    output logic signed [15:0]      o_normal_y
);

    // state with reset values
    logic signed [31:0] r_ref_px, r_ref_py;
    logic signed [15:0] r_ref_c, r_ref_s;
    logic [14:0]        r_ref_w, r_ref_h;
    logic signed [SW-1:0] r_sum_x, r_sum_y;
    logic [3:0]         r_count;
    logic [PNW-1:0]     r_best;
    logic signed [15:0] r_nx, r_ny;
    logic               r_hit;

    // working registers
    logic signed [32:0]    r_dx, r_dy;
    logic signed [15:0]    r_c, r_s;
    logic [14:0]           r_w, r_h;
    logic signed [PW-1:0]  r_prod;
    logic signed [ACW-1:0] r_acc;
    logic signed [AW-1:0]  r_rx, r_ry, r_qx, r_qy;
    logic signed [AW-1:0]  r_minx, r_maxx, r_miny, r_maxy;
    logic signed [AW-1:0]  r_lsx, r_lsy, r_lx, r_ly;
    logic [2:0]            r_n;
    logic [AW-1:0]         r_dqx, r_dqy;
    logic [1:0]            r_drx, r_dry;
    logic                  r_sgx, r_sgy;

    function automatic logic signed [15:0] neg_axis(input logic signed [15:0] a);
        return (a == 16'sh8000) ? 16'sh7fff : -a;
    endfunction

    function automatic logic signed [SW-1:0] sat_sum(input logic signed [SW+5:0] v);
        if (v[SW+5:SW-1] == '0 || v[SW+5:SW-1] == '1) begin
            return v[SW-1:0];
        end
        return v[SW+5] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
    endfunction

    // operand select and multiplier
    logic signed [AW-1:0]  w_hwx, w_hwy, w_a;
    logic signed [BW-1:0]  w_b;
    logic signed [PW-1:0]  w_mul;

    assign w_hwx = {{(AW-30){1'b0}}, r_w, 15'b0};
    assign w_hwy = {{(AW-30){1'b0}}, r_h, 15'b0};

    always_comb begin
        unique case (i_cmd.asel)
            A_X:     w_a = i_cmd.corner[1] ? w_hwx : -w_hwx;
            A_Y:     w_a = i_cmd.corner[0] ? w_hwy : -w_hwy;
            A_RX:    w_a = r_rx;
            A_RY:    w_a = r_ry;
            A_LX:    w_a = r_lx;
            A_LY:    w_a = r_ly;
            default: w_a = '0;
        endcase
        unique case (i_cmd.bsel)
            B_C:     w_b = r_c;
            B_S:     w_b = r_s;
            B_RC:    w_b = r_ref_c;
            default: w_b = r_ref_s;
        endcase
    end

    assign w_mul = w_a * w_b;

    // round half up then floor shift by 14
    logic signed [ACW-1:0] w_accr;
    logic signed [RW-1:0]  w_rnd;
    assign w_accr = r_acc + ACW'(8192);
    assign w_rnd  = $signed(w_accr[ACW-1:14]);

    logic signed [SW+5:0] w_sx, w_sy;
    assign w_sx = (SW+6)'(r_sum_x) + (SW+6)'(r_ref_px) + (SW+6)'(w_rnd);
    assign w_sy = (SW+6)'(r_sum_y) + (SW+6)'(r_ref_py) + (SW+6)'(w_rnd);

    // reference half sizes, whole units
    logic signed [AW:0] w_rhx, w_rhy, w_qx, w_qy;
    logic               w_inside;
    assign w_rhx = {{(AW-29){1'b0}}, r_ref_w[14:1], 16'b0};
    assign w_rhy = {{(AW-29){1'b0}}, r_ref_h[14:1], 16'b0};
    assign w_qx  = (AW+1)'(r_qx);
    assign w_qy  = (AW+1)'(r_qy);
    assign w_inside = (w_qx >= -w_rhx) && (w_qx <= w_rhx) &&
                      (w_qy >= -w_rhy) && (w_qy <= w_rhy);

    logic w_apart;
    assign w_apart = ((AW+1)'(r_maxx) <= -w_rhx) || ((AW+1)'(r_minx) >= w_rhx) ||
                     ((AW+1)'(r_maxy) <= -w_rhy) || ((AW+1)'(r_miny) >= w_rhy);
    assign o_stat.test_ok = !w_apart && (r_n != 3'd0);

    // divider digit for both lanes
    logic [2:0] w_remx, w_remy;
    logic       w_gex, w_gey;
    logic [2:0] w_subx, w_suby;
    assign w_remx = {r_drx, r_dqx[AW-1]};
    assign w_remy = {r_dry, r_dqy[AW-1]};
    assign w_gex  = (w_remx >= r_n);
    assign w_gey  = (w_remy >= r_n);
    assign w_subx = w_remx - r_n;
    assign w_suby = w_remy - r_n;

    // penetration candidate
    logic signed [AW:0]  w_p;
    logic [PNW-1:0]      w_ps;
    logic signed [15:0]  w_cnx, w_cny;
    logic                w_take;
    always_comb begin
        unique case (i_cmd.pen_idx)
            2'd0: begin
                w_p = w_rhx - (AW+1)'(r_minx); w_cnx = r_ref_c; w_cny = r_ref_s;
            end
            2'd1: begin
                w_p = (AW+1)'(r_maxx) + w_rhx;
                w_cnx = neg_axis(r_ref_c); w_cny = neg_axis(r_ref_s);
            end
            2'd2: begin
                w_p = w_rhy - (AW+1)'(r_miny); w_cnx = neg_axis(r_ref_s); w_cny = r_ref_c;
            end
            default: begin
                w_p = (AW+1)'(r_maxy) + w_rhy; w_cnx = r_ref_s; w_cny = neg_axis(r_ref_c);
            end
        endcase
        w_ps   = (w_p[AW:PNW] != '0) ? {PNW{1'b1}} : w_p[PNW-1:0];
        w_take = !w_p[AW] && (w_p != '0) && ((w_ps < r_best) || (r_best == '0));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_px <= '0;
            r_ref_py <= '0;
            r_ref_c  <= 16'sd16384;
            r_ref_s  <= '0;
            r_ref_w  <= '0;
            r_ref_h  <= '0;
            r_sum_x  <= '0;
            r_sum_y  <= '0;
            r_count  <= '0;
            r_best   <= '0;
            r_nx     <= '0;
            r_ny     <= '0;
            r_hit    <= 1'b0;
        end else begin
            if (i_cmd.capture) begin
                r_hit <= 1'b0;
                unique case (i_action)
                    ACT_LOAD: begin
                        r_ref_px <= i_pos_x;
                        r_ref_py <= i_pos_y;
                        r_ref_c  <= i_axis_cos;
                        r_ref_s  <= i_axis_sin;
                        r_ref_w  <= i_width;
                        r_ref_h  <= i_height;
                    end
                    ACT_CLEAR: begin
                        r_sum_x <= '0;
                        r_sum_y <= '0;
                        r_count <= '0;
                        r_best  <= '0;
                        r_nx    <= '0;
                        r_ny    <= '0;
                    end
                    default: ;
                endcase
            end
            if (i_cmd.wb == WB_SX) begin
                r_sum_x <= sat_sum(w_sx);
            end
            if (i_cmd.wb == WB_SY) begin
                r_sum_y <= sat_sum(w_sy);
            end
            if (i_cmd.cnt_inc && r_count != 4'hf) begin
                r_count <= r_count + 4'd1;
            end
            if (i_cmd.pen_try && w_take) begin
                r_best <= w_ps;
                r_nx   <= w_cnx;
                r_ny   <= w_cny;
                r_hit  <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_dx <= 33'(i_pos_x) - 33'(r_ref_px);
            r_dy <= 33'(i_pos_y) - 33'(r_ref_py);
            r_c  <= i_axis_cos;
            r_s  <= i_axis_sin;
            r_w  <= i_width;
            r_h  <= i_height;
        end
        r_prod <= w_mul;
        case (i_cmd.accop)
            ACC_LOAD: r_acc <= ACW'(r_prod);
            ACC_ADD:  r_acc <= r_acc + ACW'(r_prod);
            ACC_SUB:  r_acc <= r_acc - ACW'(r_prod);
            default:  ;
        endcase
        case (i_cmd.wb)
            WB_RX:   r_rx <= AW'(r_dx) + AW'(w_rnd);
            WB_RY:   r_ry <= AW'(r_dy) + AW'(w_rnd);
            WB_QX:   r_qx <= AW'(w_rnd);
            WB_QY:   r_qy <= AW'(w_rnd);
            default: ;
        endcase
        if (i_cmd.bound_upd) begin
            if (i_cmd.bound_first || r_qx < r_minx) r_minx <= r_qx;
            if (i_cmd.bound_first || r_qx > r_maxx) r_maxx <= r_qx;
            if (i_cmd.bound_first || r_qy < r_miny) r_miny <= r_qy;
            if (i_cmd.bound_first || r_qy > r_maxy) r_maxy <= r_qy;
            if (i_cmd.bound_first) begin
                r_n   <= w_inside ? 3'd1 : 3'd0;
                r_lsx <= w_inside ? r_qx : '0;
                r_lsy <= w_inside ? r_qy : '0;
            end else if (w_inside) begin
                r_n   <= r_n + 3'd1;
                r_lsx <= r_lsx + r_qx;
                r_lsy <= r_lsy + r_qy;
            end
        end
        // magnitude division by the inside count, truncating toward zero
        if (i_cmd.div_start) begin
            r_sgx <= r_lsx[AW-1];
            r_sgy <= r_lsy[AW-1];
            r_dqx <= r_lsx[AW-1] ? AW'(-r_lsx) : AW'(r_lsx);
            r_dqy <= r_lsy[AW-1] ? AW'(-r_lsy) : AW'(r_lsy);
            r_drx <= '0;
            r_dry <= '0;
        end
        if (i_cmd.div_step) begin
            r_dqx <= {r_dqx[AW-2:0], w_gex};
            r_dqy <= {r_dqy[AW-2:0], w_gey};
            r_drx <= w_gex ? w_subx[1:0] : w_remx[1:0];
            r_dry <= w_gey ? w_suby[1:0] : w_remy[1:0];
        end
        if (i_cmd.div_fin) begin
            r_lx <= r_sgx ? -$signed(r_dqx) : $signed(r_dqx);
            r_ly <= r_sgy ? -$signed(r_dqy) : $signed(r_dqy);
        end
    end

    assign o_hit           = r_hit;
    assign o_contact_sum_x = r_sum_x;
    assign o_contact_sum_y = r_sum_y;
    assign o_contact_count = r_count;
    assign o_penetration   = r_best;
    assign o_normal_x      = r_nx;
    assign o_normal_y      = r_ny;

endmodule
`default_nettype wire

@@ design/oriented_box_corner_contact_unit.sv @@
// top level of the oriented box corner contact unit
// depends on obcc_pkg, obcc_ctrl, obcc_datapath
//
// channel   direction  handshake           payload
// request   in         i_valid / o_stall   action, pos, axis, width, height
// result    out        o_valid / i_stall   hit, contact sums, count, penetration, normal
//
// load and clear requests give their result in the cycle after acceptance
// a test runs the four corners through the one shared multiplier, then a bounds check;
// without a contact it goes straight to the result cycle, and with one it goes on to a
// radix-2 divide by the inside count, the back rotation, 4 penetration steps and the
// result cycle
// one request at a time; o_stall stays high until the result is taken
// reset is synchronous, active low, and restores the reference and accumulators
`default_nettype none
module oriented_box_corner_contact_unit
    import obcc_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic [1:0]         i_action,
    input  wire logic signed [31:0] i_pos_x,
    input  wire logic signed [31:0] i_pos_y,
    input  wire logic signed [15:0] i_axis_cos,
    input  wire logic signed [15:0] i_axis_sin,
    input  wire logic [14:0]        i_width,
    input  wire logic [14:0]        i_height,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic                    o_hit,
    output logic signed [39:0]      o_contact_sum_x,
    output logic signed [39:0]      o_contact_sum_y,
    output logic [3:0]              o_contact_count,
    output logic [30:0]             o_penetration,
    output logic signed [15:0]      o_normal_x,
    output logic signed [15:0]      o_normal_y
);

    t_cmd  w_cmd;
    t_stat w_stat;

    obcc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_action (i_action),
        .o_stall  (o_stall),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .i_stat   (w_stat),
        .o_cmd    (w_cmd)
    );

    obcc_datapath u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .i_action        (i_action),
        .i_pos_x         (i_pos_x),
        .i_pos_y         (i_pos_y),
        .i_axis_cos      (i_axis_cos),
        .i_axis_sin      (i_axis_sin),
        .i_width         (i_width),
        .i_height        (i_height),
        .o_hit           (o_hit),
        .o_contact_sum_x (o_contact_sum_x),
        .o_contact_sum_y (o_contact_sum_y),
        .o_contact_count (o_contact_count),
        .o_penetration   (o_penetration),
        .o_normal_x      (o_normal_x),
        .o_normal_y      (o_normal_y)
    );

endmodule
`default_nettype wire

@@ design/obcc_checker.sv @@
// port-level checks of the contact unit, bound to the top level
// depends on oriented_box_corner_contact_unit_assert.svh
`default_nettype none
`include "oriented_box_corner_contact_unit_assert.svh"
module obcc_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_stall,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic        o_hit,
    input wire logic [3:0]  o_contact_count,
    input wire logic [30:0] o_penetration
);

    // a waiting result holds until taken
    `OBCC_ASSERT_NEXT(a_valid_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid)
    // no new request while a result waits
    `OBCC_ASSERT_NOW(a_busy_out, i_clk, i_rst_n, o_valid, o_stall)
    // a hit always leaves a penetration kept
    `OBCC_ASSERT_NOW(a_hit_pen, i_clk, i_rst_n, o_valid && o_hit, o_penetration != 31'd0)
    // a hit only follows a counted contact
    `OBCC_ASSERT_NOW(a_hit_cnt, i_clk, i_rst_n, o_valid && o_hit, o_contact_count != 4'd0)

endmodule

bind oriented_box_corner_contact_unit obcc_checker u_obcc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_stall         (o_stall),
    .o_valid         (o_valid),
    .i_stall         (i_stall),
    .o_hit           (o_hit),
    .o_contact_count (o_contact_count),
    .o_penetration   (o_penetration)
);
`default_nettype wire
